[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the circular FIFO.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition never seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[rtl/core/cfwr_pkg.sv]
// Shared constants and types for the circular FIFO with in-place reverse.
// No dependencies.
package cfwr_pkg;

	localparam int DATA_W    = 32;
	localparam int CNT_W     = 5;
	localparam int DEPTH_DEF = 16;
	localparam int CAP_RESET = 16;

	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_REV   = 3'd4
	} cmd_t;

endpackage

[rtl/core/cfwr_ram.sv]
// Word store for the FIFO: one write port, two registered read ports.
// Depends on cfwr_pkg.
module cfwr_ram import cfwr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr_a,
	input  logic [AW-1:0]     raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/core/circular_fifo_with_reverse_top.sv]
// Circular FIFO of signed 32-bit words with push, pop, peek, clear and reverse.
// Depends on cfwr_pkg, cfwr_ram and assert_macros.svh.
//
//  channel   handshake              payload
//  in        in_valid / in_ready    command, value
//  out       out_valid / out_ready  ok, value_out, count, empty_res, full_res
//  cfg       cfg_we (no wait)       cfg_wdata (capacity)
//
// Push, clear, failed commands and reverse of under two words finish in ST_IDLE.
// Pop and peek finish in ST_READ, as the read ports of the word store are registered.
// Reverse of n words: floor(n/2) swaps of ST_SW_RD, ST_SW_WL, ST_SW_WR (read pair, write left, write right).
// Reset sets state, capacity, pointers and count; the word store has no clearing pass.
// A result waiting on out_ready parks in a hold register; a further word is
// taken only once the hold register is free.
module circular_fifo_with_reverse_top import cfwr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               command,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     ok,
	output logic signed [DATA_W-1:0] value_out,
	output logic [CNT_W-1:0]         count,
	output logic                     empty_res,
	output logic                     full_res,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_wdata
);

	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'((DEPTH > 31) ? 31 : DEPTH);
	localparam logic [IDX_W-1:0] TAIL_RST =
		IDX_W'(((CAP_RESET > DEPTH) ? DEPTH : CAP_RESET) - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SW_RD,
		ST_SW_WL,
		ST_SW_WR,
		ST_HOLD
	} state_t;

	function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (r == '0) r = CNT_W'(1);
		if (r > CAP_MAX) r = CAP_MAX;
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] cap_last(input logic [CNT_W-1:0] c);
		logic [CMP_W-1:0] ce;
		ce = {{(CMP_W-CNT_W){1'b0}}, c} - CMP_W'(1);
		return ce[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] c);
		logic [CMP_W-1:0] ie;
		logic [CMP_W-1:0] ce;
		ie = {{(CMP_W-IDX_W){1'b0}}, i} + CMP_W'(1);
		ce = {{(CMP_W-CNT_W){1'b0}}, c};
		return (ie >= ce) ? '0 : ie[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] c);
		logic [CMP_W-1:0] ie;
		logic [CMP_W-1:0] ce;
		ie = {{(CMP_W-IDX_W){1'b0}}, i};
		ce = {{(CMP_W-CNT_W){1'b0}}, c};
		return (i == '0 || ie >= ce) ? cap_last(c) : i - IDX_W'(1);
	endfunction

	state_t             state_q, state_n;
	logic [CNT_W-1:0]   capacity_q;
	logic [IDX_W-1:0]   head_q, head_n;
	logic [IDX_W-1:0]   tail_q, tail_n;
	logic [CNT_W-1:0]   count_q, count_n;
	logic [IDX_W-1:0]   left_q, left_n;
	logic [IDX_W-1:0]   right_q, right_n;
	logic [CNT_W-1:0]   swaps_q, swaps_n;
	logic               out_valid_q, out_valid_n;

	logic               out_ok_q, out_empty_q, out_full_q;
	logic [DATA_W-1:0]  out_val_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic               hold_ok_q;
	logic [DATA_W-1:0]  hold_val_q;
	logic [CNT_W-1:0]   hold_cnt_q;
	logic [DATA_W-1:0]  swap_q;

	logic [CNT_W-1:0]   cap;
	logic               acc, out_free;
	logic               fin, fin_ok;
	logic [DATA_W-1:0]  fin_val;
	logic               load_out, load_hold, from_hold;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
	logic [DATA_W-1:0]  ram_wdata, ram_rdata_a, ram_rdata_b;

	assign cap      = eff_cap(capacity_q);
	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_n     = state_q;
		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		left_n      = left_q;
		right_n     = right_q;
		swaps_n     = swaps_q;
		fin         = 1'b0;
		fin_ok      = 1'b0;
		fin_val     = '0;
		ram_we      = 1'b0;
		ram_waddr   = tail_q;
		ram_wdata   = value;
		ram_raddr_a = left_q;
		ram_raddr_b = right_q;
		from_hold   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (command)
						CMD_PUSH: begin
							fin = 1'b1;
							if (count_q < cap) begin
								tail_n    = next_idx(tail_q, cap);
								ram_we    = 1'b1;
								ram_waddr = tail_n;
								count_n   = count_q + CNT_W'(1);
								fin_ok    = 1'b1;
							end
						end
						CMD_POP: begin
							if (count_q != '0) begin
								ram_raddr_a = head_q;
								head_n      = next_idx(head_q, cap);
								count_n     = count_q - CNT_W'(1);
								state_n     = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						CMD_PEEK: begin
							if (count_q != '0) begin
								ram_raddr_a = head_q;
								state_n     = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						CMD_CLEAR: begin
							head_n  = '0;
							tail_n  = cap_last(cap);
							count_n = '0;
							fin     = 1'b1;
							fin_ok  = 1'b1;
						end
						CMD_REV: begin
							if (count_q < CNT_W'(2)) begin
								fin    = 1'b1;
								fin_ok = 1'b1;
							end else begin
								left_n  = head_q;
								right_n = tail_q;
								swaps_n = '0;
								state_n = ST_SW_RD;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				fin     = 1'b1;
				fin_ok  = 1'b1;
				fin_val = ram_rdata_a;
			end
			ST_SW_RD: begin
				if (swaps_q == (count_q >> 1)) begin
					fin    = 1'b1;
					fin_ok = 1'b1;
				end else begin
					state_n = ST_SW_WL;
				end
			end
			ST_SW_WL: begin
				ram_we    = 1'b1;
				ram_waddr = left_q;
				ram_wdata = ram_rdata_b;
				state_n   = ST_SW_WR;
			end
			ST_SW_WR: begin
				ram_we    = 1'b1;
				ram_waddr = right_q;
				ram_wdata = swap_q;
				left_n    = next_idx(left_q, cap);
				right_n   = prev_idx(right_q, cap);
				swaps_n   = swaps_q + CNT_W'(1);
				state_n   = ST_SW_RD;
			end
			ST_HOLD: begin
				if (out_free) begin
					from_hold = 1'b1;
					state_n   = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		load_out  = (fin && out_free) || from_hold;
		load_hold = fin && !out_free;
		if (fin) begin
			state_n = out_free ? ST_IDLE : ST_HOLD;
		end

		if (load_out) begin
			out_valid_n = 1'b1;
		end else if (out_ready) begin
			out_valid_n = 1'b0;
		end else begin
			out_valid_n = out_valid_q;
		end
	end

	// control state; a capacity write is honoured only with the queue empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= CNT_W'(CAP_RESET);
			head_q      <= '0;
			tail_q      <= TAIL_RST;
			count_q     <= '0;
			left_q      <= '0;
			right_q     <= '0;
			swaps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			count_q     <= count_n;
			left_q      <= left_n;
			right_q     <= right_n;
			swaps_q     <= swaps_n;
			out_valid_q <= out_valid_n;
			if (cfg_we && count_q == '0) begin
				capacity_q <= cfg_wdata;
				head_q     <= '0;
				tail_q     <= cap_last(eff_cap(cfg_wdata));
			end else begin
				head_q <= head_n;
				tail_q <= tail_n;
			end
		end
	end

	// result words and swap temporary; cap is constant during a reverse, as count_q stays above one
	always_ff @(posedge clk) begin
		if (state_q == ST_SW_WL) begin
			swap_q <= ram_rdata_a;
		end
		if (load_hold) begin
			hold_ok_q  <= fin_ok;
			hold_val_q <= fin_val;
			hold_cnt_q <= count_n;
		end
		if (from_hold) begin
			out_ok_q    <= hold_ok_q;
			out_val_q   <= hold_val_q;
			out_cnt_q   <= hold_cnt_q;
			out_empty_q <= (hold_cnt_q == '0);
			out_full_q  <= (hold_cnt_q == cap);
		end else if (load_out) begin
			out_ok_q    <= fin_ok;
			out_val_q   <= fin_val;
			out_cnt_q   <= count_n;
			out_empty_q <= (count_n == '0);
			out_full_q  <= (count_n == cap);
		end
	end

	// in ST_SW_RD the store is read at left_q / right_q by default
	cfwr_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(ram_rdata_a),
		.rdata_b(ram_rdata_b)
	);

	assign out_valid = out_valid_q;
	assign ok        = out_ok_q;
	assign value_out = out_val_q;
	assign count     = out_cnt_q;
	assign empty_res = out_empty_q;
	assign full_res  = out_full_q;

	`ASSERT_NEVER(a_count_in_cap, clk, arst_n, count_q > cap, "count exceeds capacity")
	`ASSERT_AT(a_hold_needs_out, clk, arst_n, (state_q == ST_HOLD) |-> out_valid_q, "hold with output free")
	`ASSERT_AT(a_read_after_acc, clk, arst_n, (state_q == ST_READ) |-> $past(acc), "read without a word")
	`ASSERT_NEVER(a_swaps_bound, clk, arst_n, (state_q == ST_SW_RD || state_q == ST_SW_WL || state_q == ST_SW_WR) && (swaps_q > (count_q >> 1)), "too many swaps")
	`ASSERT_AT(a_no_drop, clk, arst_n, (out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_val_q)), "result lost while stalled")

endmodule
